// ===== rtl/core/tga_rle_pkg.sv =====
// types and constants shared by the tga rle pixel decoder
// no dependencies
`default_nettype none

package tga_rle_pkg;

   // decoder phases
   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PACKET,
      PH_PIXEL,
      PH_DONE
   } phase_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_PIXEL     = 2'd0,
      ST_BAD_TYPE  = 2'd1,
      ST_BAD_DEPTH = 2'd2,
      ST_TRUNCATED = 2'd3
   } status_type;

   // header byte positions
   localparam logic [4:0] HdrIdLen    = 5'd0;
   localparam logic [4:0] HdrType     = 5'd2;
   localparam logic [4:0] HdrCmLenLo  = 5'd5;
   localparam logic [4:0] HdrCmLenHi  = 5'd6;
   localparam logic [4:0] HdrCmBits   = 5'd7;
   localparam logic [4:0] HdrWidthLo  = 5'd12;
   localparam logic [4:0] HdrWidthHi  = 5'd13;
   localparam logic [4:0] HdrHeightLo = 5'd14;
   localparam logic [4:0] HdrHeightHi = 5'd15;
   localparam logic [4:0] HdrDepth    = 5'd16;
   localparam logic [4:0] HdrDesc     = 5'd17;

   localparam logic [7:0] TypeRaw  = 8'd2;
   localparam logic [7:0] TypeRle  = 8'd10;
   localparam logic [7:0] Depth24  = 8'd24;
   localparam logic [7:0] Depth32  = 8'd32;
   localparam logic [7:0] AlphaOpaque = 8'hff;

   localparam int SkipWidth = 22;

   // result queue
   localparam int QueueDepth = 4;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);

   typedef struct packed {
      status_type status;
      logic       top_origin;
      logic       has_alpha;
      logic       final_pixel;
      logic [7:0] repeat_count;
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
// tga rle pixel decoder top level: header parse, skip, pixel decode, result queue
// depends on tga_rle_pkg
//
//  channel | dir | beat content
//  req_    | in  | tdata[7:0] data_byte, tlast end_of_file
//  rsp_    | out | tdata red,green,blue,alpha,repeat_count; tlast final_pixel;
//          |     | tuser has_alpha,top_origin,status
//
// one byte is taken per cycle while req_tready is high; its results are written
// into a four entry result queue in the same cycle and can leave on the next cycle.
// req_tready stays high while the queue has room for two results, so the
// input side only stalls when rsp_ is stalled.
// reset is synchronous; after a byte with tlast the decoder is back in its
// header phase and the next byte starts a new file.
`default_nettype none

module tga_rle_pixel_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // red, green, blue, alpha, repeat_count
   output logic             rsp_tlast,
   output logic [3:0]       rsp_tuser    // has_alpha, top_origin, status[1:0]
);

   import tga_rle_pkg::*;

   // decoder state
   phase_type            phase_ff, phase_in;
   logic [4:0]           hdr_idx_ff, hdr_idx_in;
   logic [7:0]           img_type_ff, img_type_in;
   logic [15:0]          cm_len_ff, cm_len_in;
   logic [15:0]          width_ff, width_in;
   logic [15:0]          height_ff, height_in;
   logic [7:0]           depth_ff, depth_in;
   logic                 top_ff, top_in;
   logic [SkipWidth-1:0] skip_ff, skip_in;
   logic [31:0]          pixels_ff, pixels_in;
   logic [7:0]           pkt_left_ff, pkt_left_in;
   logic                 pkt_run_ff, pkt_run_in;
   logic [1:0]           bip_ff, bip_in;
   logic [23:0]          pix_buf_ff, pix_buf_in;

   // result queue
   result_type            queue_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic       accept;
   logic       pop;
   logic       first_valid;
   result_type first_item;
   result_type trunc_item;
   result_type head;

   // pixel datapath helpers
   logic                 is_rle;
   logic                 is32;
   logic                 pix_done;
   logic [23:0]          buf_next;
   logic [7:0]           rep;
   logic [31:0]          pixels_after;
   logic [8:0]           cm_bits_round;
   logic [21:0]          cm_bytes;
   logic                 hdr_bad_type;
   logic                 hdr_bad_depth;
   logic [SkipWidth-1:0] skip_hdr;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff <= CountWidth'(QueueDepth - 2));
   assign rsp_tvalid = (count_ff != '0);

   assign is_rle = (img_type_ff == TypeRle);
   assign is32   = (depth_ff == Depth32);

   assign cm_bits_round = {1'b0, req_tdata} + 9'd7;
   assign cm_bytes      = {6'd0, cm_len_ff} * {16'd0, cm_bits_round[8:3]};

   assign hdr_bad_type  = (img_type_ff != TypeRaw) && (img_type_ff != TypeRle);
   assign hdr_bad_depth = (depth_ff != Depth24) && (depth_ff != Depth32);

   // pixel byte gathering, stored order is b, g, r; alpha is not stored
   always_comb begin
      buf_next = (bip_ff == 2'd0) ? 24'd0 : pix_buf_ff;
      unique case (bip_ff)
         2'd0:    buf_next[7:0]   = req_tdata;
         2'd1:    buf_next[15:8]  = req_tdata;
         2'd2:    buf_next[23:16] = req_tdata;
         default: buf_next = pix_buf_ff;
      endcase
   end

   assign pix_done = is32 ? (bip_ff == 2'd3) : (bip_ff >= 2'd2);

   always_comb begin
      if (is_rle && pkt_run_ff) begin
         rep = (pixels_ff < {24'd0, pkt_left_ff}) ? pixels_ff[7:0] : pkt_left_ff;
      end else begin
         rep = 8'd1;
      end
   end

   assign pixels_after = pixels_ff - {24'd0, rep};
   assign skip_hdr     = skip_ff;

   // next state
   always_comb begin
      phase_in    = phase_ff;
      hdr_idx_in  = hdr_idx_ff;
      img_type_in = img_type_ff;
      cm_len_in   = cm_len_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      depth_in    = depth_ff;
      top_in      = top_ff;
      skip_in     = skip_ff;
      pixels_in   = pixels_ff;
      pkt_left_in = pkt_left_ff;
      pkt_run_in  = pkt_run_ff;
      bip_in      = bip_ff;
      pix_buf_in  = pix_buf_ff;

      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               hdr_idx_in = hdr_idx_ff + 5'd1;
               unique case (hdr_idx_ff)
                  HdrIdLen:    skip_in = SkipWidth'(req_tdata);
                  HdrType:     img_type_in = req_tdata;
                  HdrCmLenLo:  cm_len_in[7:0] = req_tdata;
                  HdrCmLenHi:  cm_len_in[15:8] = req_tdata;
                  HdrCmBits:   skip_in = skip_ff + cm_bytes;
                  HdrWidthLo:  width_in[7:0] = req_tdata;
                  HdrWidthHi:  width_in[15:8] = req_tdata;
                  HdrHeightLo: height_in[7:0] = req_tdata;
                  HdrHeightHi: height_in[15:8] = req_tdata;
                  HdrDepth: begin
                     depth_in  = req_tdata;
                     pixels_in = {16'd0, width_ff} * {16'd0, height_ff};
                  end
                  HdrDesc:     top_in = req_tdata[5];
                  default: ;
               endcase
               if (hdr_idx_ff == HdrDesc) begin
                  pkt_left_in = 8'd0;
                  pkt_run_in  = 1'b0;
                  bip_in      = 2'd0;
                  pix_buf_in  = 24'd0;
                  if (hdr_bad_type || hdr_bad_depth) begin
                     phase_in = PH_DONE;
                  end else if (skip_hdr != '0) begin
                     phase_in = PH_SKIP;
                  end else if (pixels_ff == 32'd0) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = is_rle ? PH_PACKET : PH_PIXEL;
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - SkipWidth'(1);
               if (skip_ff == SkipWidth'(1)) begin
                  pkt_left_in = 8'd0;
                  pkt_run_in  = 1'b0;
                  bip_in      = 2'd0;
                  pix_buf_in  = 24'd0;
                  if (pixels_ff == 32'd0) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = is_rle ? PH_PACKET : PH_PIXEL;
                  end
               end
            end
            PH_PACKET: begin
               pkt_run_in  = req_tdata[7];
               pkt_left_in = {1'b0, req_tdata[6:0]} + 8'd1;
               bip_in      = 2'd0;
               pix_buf_in  = 24'd0;
               phase_in    = PH_PIXEL;
            end
            PH_PIXEL: begin
               if (pix_done) begin
                  bip_in     = 2'd0;
                  pix_buf_in = 24'd0;
                  pixels_in  = pixels_after;
                  if (is_rle && pkt_run_ff) begin
                     pkt_left_in = 8'd0;
                  end else if (is_rle && pkt_left_ff != 8'd0) begin
                     pkt_left_in = pkt_left_ff - 8'd1;
                  end
                  if (pixels_after == 32'd0) begin
                     phase_in = PH_DONE;
                  end else if (is_rle && pkt_left_in == 8'd0) begin
                     phase_in = PH_PACKET;
                  end else begin
                     phase_in = PH_PIXEL;
                  end
               end else begin
                  bip_in     = bip_ff + 2'd1;
                  pix_buf_in = buf_next;
               end
            end
            PH_DONE: ;
            default: phase_in = PH_DONE;
         endcase

         if (req_tlast) begin
            phase_in   = PH_HEADER;
            hdr_idx_in = 5'd0;
            skip_in    = '0;
            pixels_in  = 32'd0;
         end
      end
   end

   // results of the accepted byte
   always_comb begin
      first_valid = 1'b0;
      first_item  = '0;
      trunc_item  = '0;
      trunc_item.status = ST_TRUNCATED;

      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hdr_idx_ff == HdrDesc) begin
                  if (hdr_bad_type) begin
                     first_valid       = 1'b1;
                     first_item.status = ST_BAD_TYPE;
                  end else if (hdr_bad_depth) begin
                     first_valid       = 1'b1;
                     first_item.status = ST_BAD_DEPTH;
                  end
               end
            end
            PH_PIXEL: begin
               if (pix_done) begin
                  first_valid             = 1'b1;
                  first_item.red          = buf_next[23:16];
                  first_item.green        = buf_next[15:8];
                  first_item.blue         = buf_next[7:0];
                  first_item.alpha        = is32 ? req_tdata : AlphaOpaque;
                  first_item.repeat_count = rep;
                  first_item.final_pixel  = (pixels_after == 32'd0);
                  first_item.has_alpha    = is32;
                  first_item.top_origin   = top_ff;
                  first_item.status       = ST_PIXEL;
               end
            end
            default: ;
         endcase
      end
   end

   // eof check must use the phase before the eof return to header
   logic phase_pre_done;
   always_comb begin
      phase_pre_done = 1'b0;
      if (phase_ff == PH_DONE) begin
         phase_pre_done = 1'b1;
      end else if (phase_ff == PH_HEADER && hdr_idx_ff == HdrDesc) begin
         phase_pre_done = hdr_bad_type || hdr_bad_depth ||
                          (skip_hdr == '0 && pixels_ff == 32'd0);
      end else if (phase_ff == PH_SKIP && skip_ff == SkipWidth'(1)) begin
         phase_pre_done = (pixels_ff == 32'd0);
      end else if (phase_ff == PH_PIXEL && pix_done) begin
         phase_pre_done = (pixels_after == 32'd0);
      end
   end

   logic trunc_push;
   assign trunc_push = accept && req_tlast && !phase_pre_done;

   // queue pointers
   always_comb begin
      logic [CountWidth-1:0] n_push;
      n_push    = CountWidth'(first_valid) + CountWidth'(trunc_push);
      wr_ptr_in = wr_ptr_ff + PtrWidth'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + PtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff + n_push - CountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (first_valid) begin
         queue_ff[wr_ptr_ff] <= first_item;
      end else if (trunc_push) begin
         queue_ff[wr_ptr_ff] <= trunc_item;
      end
      if (first_valid && trunc_push) begin
         queue_ff[wr_ptr_ff + PtrWidth'(1)] <= trunc_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hdr_idx_ff  <= 5'd0;
         skip_ff     <= '0;
         pixels_ff   <= 32'd0;
         pkt_left_ff <= 8'd0;
         pkt_run_ff  <= 1'b0;
         bip_ff      <= 2'd0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         skip_ff     <= skip_in;
         pixels_ff   <= pixels_in;
         pkt_left_ff <= pkt_left_in;
         pkt_run_ff  <= pkt_run_in;
         bip_ff      <= bip_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   // header fields and pixel bytes, rewritten before use
   always_ff @(posedge clock) begin
      img_type_ff <= img_type_in;
      cm_len_ff   <= cm_len_in;
      width_ff    <= width_in;
      height_ff   <= height_in;
      depth_ff    <= depth_in;
      top_ff      <= top_in;
      pix_buf_ff  <= pix_buf_in;
   end

   assign head = queue_ff[rd_ptr_ff];

   assign rsp_tdata = {head.repeat_count, head.alpha, head.blue, head.green, head.red};
   assign rsp_tlast = head.final_pixel;
   assign rsp_tuser = {head.status, head.top_origin, head.has_alpha};

endmodule

`default_nettype wire

// ===== tb/tb_tga_rle_pixel_decoder.sv =====
// testbench for tga_rle_pixel_decoder: streams directed and random tga files
// byte by byte, predicts the pixel and error beats, checks them in order
// depends on tga_rle_pkg and the decoder rtl
`default_nettype none

module tb_tga_rle_pixel_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import tga_rle_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } tga_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // red, green, blue, alpha, repeat_count
   logic        rsp_tlast;
   logic [3:0]  rsp_tuser;          // has_alpha, top_origin, status[1:0]

   tga_rle_pixel_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tga_beat_type pending_bytes[$];
   logic [7:0]  file_bytes[$];
   result_type  expected_pixels[$];
   int          beats_sent = 0;
   int          beats_taken = 0;
   int          total_beats = 0;
   int          mismatches = 0;
   int          send_gap = 0;
   int          recv_gap = 0;
   int unsigned cycle_count = 0;
   wire         hold_off = cycle_count >= 600 && cycle_count < 900;
   wire         calm = (cycle_count % 1500) < 250;

   // decoder copy
   phase_type   dec_phase;
   logic [4:0]  hdr_pos;
   logic [7:0]  img_type;
   logic [15:0] cmap_len;
   logic [15:0] img_width;
   logic [15:0] img_height;
   logic [7:0]  img_depth;
   logic [7:0]  descriptor;
   int unsigned skip_count;
   logic [31:0] pix_left;
   int unsigned pkt_left;
   logic        pkt_run;
   int unsigned byte_pos;
   logic [23:0] pbuf;

   task automatic reset_decoder();
      dec_phase = PH_HEADER;
      hdr_pos = '0;
      img_type = '0;
      cmap_len = '0;
      img_width = '0;
      img_height = '0;
      img_depth = '0;
      descriptor = '0;
      skip_count = 0;
      pix_left = '0;
      pkt_left = 0;
      pkt_run = 1'b0;
      byte_pos = 0;
      pbuf = '0;
   endtask

   task automatic start_pixels();
      byte_pos = 0;
      pbuf = '0;
      pkt_left = 0;
      pkt_run = 1'b0;
      if (pix_left == 0)
         dec_phase = PH_DONE;
      else
         dec_phase = (img_type == TypeRle) ? PH_PACKET : PH_PIXEL;
   endtask

   task automatic push_error(input status_type st);
      result_type err;
      err = '0;
      err.status = st;
      expected_pixels.push_back(err);
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eof);
      int unsigned bpp;
      int unsigned rep;
      logic        rle;
      result_type  px;
      rle = img_type == TypeRle;
      bpp = (img_depth == Depth32) ? 4 : 3;
      case (dec_phase)
         PH_HEADER: begin
            case (hdr_pos)
               HdrIdLen:    skip_count = b;
               HdrType:     img_type = b;
               HdrCmLenLo:  cmap_len[7:0] = b;
               HdrCmLenHi:  cmap_len[15:8] = b;
               HdrCmBits:   skip_count += int'(cmap_len) * ((int'(b) + 7) >> 3);
               HdrWidthLo:  img_width[7:0] = b;
               HdrWidthHi:  img_width[15:8] = b;
               HdrHeightLo: img_height[7:0] = b;
               HdrHeightHi: img_height[15:8] = b;
               HdrDepth:    img_depth = b;
               HdrDesc:     descriptor = b;
               default: ;
            endcase
            if (hdr_pos == HdrDesc) begin
               if (img_type != TypeRaw && img_type != TypeRle) begin
                  push_error(ST_BAD_TYPE);
                  dec_phase = PH_DONE;
               end else if (img_depth != Depth24 && img_depth != Depth32) begin
                  push_error(ST_BAD_DEPTH);
                  dec_phase = PH_DONE;
               end else begin
                  pix_left = {16'd0, img_width} * {16'd0, img_height};
                  if (skip_count != 0)
                     dec_phase = PH_SKIP;
                  else
                     start_pixels();
               end
            end
            hdr_pos = hdr_pos + 5'd1;
         end
         PH_SKIP: begin
            if (skip_count != 0)
               skip_count--;
            if (skip_count == 0)
               start_pixels();
         end
         PH_PACKET: begin
            pkt_run = b[7];
            pkt_left = int'(b[6:0]) + 1;
            byte_pos = 0;
            pbuf = '0;
            dec_phase = PH_PIXEL;
         end
         PH_PIXEL: begin
            if (byte_pos == 0)
               pbuf = '0;
            if (byte_pos < 3)
               pbuf[8*byte_pos +: 8] = b;
            if (byte_pos + 1 >= bpp) begin
               if (rle && pkt_run) begin
                  rep = (pkt_left < pix_left) ? pkt_left : pix_left;
                  pkt_left = 0;
               end else begin
                  rep = 1;
                  if (rle && pkt_left != 0)
                     pkt_left--;
               end
               if (rep > pix_left)
                  rep = pix_left;
               pix_left -= rep;
               px.red = pbuf[23:16];
               px.green = pbuf[15:8];
               px.blue = pbuf[7:0];
               px.alpha = (bpp == 4) ? b : AlphaOpaque;
               px.repeat_count = rep[7:0];
               px.final_pixel = pix_left == 0;
               px.has_alpha = bpp == 4;
               px.top_origin = descriptor[5];
               px.status = ST_PIXEL;
               expected_pixels.push_back(px);
               byte_pos = 0;
               pbuf = '0;
               if (px.final_pixel)
                  dec_phase = PH_DONE;
               else if (rle && pkt_left == 0)
                  dec_phase = PH_PACKET;
               else
                  dec_phase = PH_PIXEL;
            end else begin
               byte_pos = byte_pos + 1;
            end
         end
         default: ;
      endcase
      if (eof) begin
         if (dec_phase != PH_DONE)
            push_error(ST_TRUNCATED);
         reset_decoder();
      end
   endtask

   task automatic report(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want)
         report($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // ---------------- stimulus building ----------------

   task automatic put_byte(input int v);
      file_bytes.push_back(8'(v));
   endtask

   task automatic put_random(input int n);
      repeat (n) put_byte($urandom_range(0, 255));
   endtask

   task automatic put_header(input int id_len, input int img, input int cm_len,
                             input int cm_bits, input int w, input int h,
                             input int depth, input int desc);
      put_byte(id_len);
      put_random(1);
      put_byte(img);
      put_random(2);
      put_byte(cm_len);
      put_byte(cm_len >> 8);
      put_byte(cm_bits);
      put_random(4);
      put_byte(w);
      put_byte(w >> 8);
      put_byte(h);
      put_byte(h >> 8);
      put_byte(depth);
      put_byte(desc);
   endtask

   // cut > 0 keeps only the first cut bytes; the last byte carries end of file
   task automatic close_file(input int cut);
      tga_beat_type bt;
      if (cut > 0)
         while (file_bytes.size() > cut)
            void'(file_bytes.pop_back());
      foreach (file_bytes[k]) begin
         bt.data = file_bytes[k];
         bt.last = k == file_bytes.size() - 1;
         pending_bytes.push_back(bt);
      end
      file_bytes.delete();
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic random_file();
      int  roll, id_len, cm_len, cm_bits, w, h, bpp, left, cnt, n;
      int  img, depth;
      bit  rle;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         // plain noise, mostly rejected or cut off in the header
         put_random($urandom_range(1, 30));
         close_file(0);
         return;
      end
      rle = $urandom_range(0, 1);
      img = rle ? TypeRle : TypeRaw;
      depth = $urandom_range(0, 1) ? Depth32 : Depth24;
      if (roll < 15) begin
         do img = $urandom_range(0, 255); while (img == TypeRaw || img == TypeRle);
      end else if (roll < 22) begin
         do depth = $urandom_range(0, 255); while (depth == Depth24 || depth == Depth32);
      end
      id_len = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 6);
      cm_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      cm_bits = $urandom_range(0, 255);
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      put_header(id_len, img, cm_len, cm_bits, w, h, depth, $urandom_range(0, 255));
      put_random(id_len + cm_len * ((cm_bits + 7) / 8));
      bpp = (depth == Depth32) ? 4 : 3;
      left = w * h;
      while (left > 0) begin
         if (!rle) begin
            put_random(bpp);
            left--;
         end else begin
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
            if ($urandom_range(0, 1)) begin
               put_byte({1'b1, 7'(cnt - 1)});
               put_random(bpp);
               left -= (cnt < left) ? cnt : left;
            end else begin
               // a raw packet may overrun the image by one pixel
               put_byte({1'b0, 7'(cnt - 1)});
               n = (cnt < left + 1) ? cnt : left + 1;
               put_random(n * bpp);
               left -= (cnt < left) ? cnt : left;
            end
         end
      end
      if ($urandom_range(0, 3) == 0)
         put_random($urandom_range(1, 3));
      if ($urandom_range(0, 6) == 0 && file_bytes.size() > 1)
         close_file($urandom_range(1, file_bytes.size() - 1));
      else
         close_file(0);
   endtask

   task automatic directed_files();
      // unsupported type wins over unsupported depth
      put_header(0, 3, 0, 0, 1, 1, 8, 0);
      close_file(0);
      put_header(0, TypeRle, 0, 0, 1, 1, 16, 0);
      close_file(0);
      // empty image with trailing bytes
      put_header(0, TypeRaw, 0, 0, 0, 3, Depth24, 8'hff);
      put_byte(8'h00);
      put_byte(8'hff);
      close_file(0);
      // raw 24 bit with id field and colour map, top origin
      put_header(2, TypeRaw, 1, 24, 2, 1, Depth24, 8'h20);
      put_random(5);
      put_byte(8'h00); put_byte(8'hff); put_byte(8'h55);
      put_byte(8'hff); put_byte(8'h00); put_byte(8'haa);
      close_file(0);
      // run clipped to the pixels left, right-to-left bit ignored
      put_header(0, TypeRle, 0, 0, 3, 1, Depth32, 8'h10);
      put_byte(8'hff);
      put_random(4);
      close_file(0);
      // raw packet overrunning the last pixel, spare bytes trail
      put_header(0, TypeRle, 0, 0, 2, 2, Depth24, 8'hdf);
      put_byte(8'h05);
      put_random(18);
      close_file(0);
      // truncated inside the header
      put_random(5);
      close_file(0);
      // huge image cut off right on a pixel: pixel beats then truncation
      put_header(0, TypeRle, 0, 0, 16'hffff, 16'hffff, Depth32, 8'h28);
      put_byte(8'hff); put_random(4);
      put_byte(8'hff); put_random(4);
      close_file(0);
      // truncated inside a long id field and a huge colour map
      put_header(255, TypeRaw, 0, 0, 1, 1, Depth24, 0);
      put_random(10);
      close_file(0);
      put_header(0, TypeRle, 16'hffff, 255, 1, 1, Depth32, 0);
      put_random(3);
      close_file(0);
   endtask

   // ---------------- drivers and checker ----------------

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   always @(negedge clock) begin : drive_bytes
      tga_beat_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || beats_taken == beats_sent) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            nxt = pending_bytes.pop_front();
            req_tdata <= nxt.data;
            req_tlast <= nxt.last;
            req_tvalid <= 1'b1;
            beats_sent++;
            send_gap = calm ? 0 : pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || hold_off) begin
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0)
            recv_gap = pick_gap();
      end
   end

   // results are checked before the byte of this edge is predicted
   always @(posedge clock) begin : scoreboard
      result_type want;
      if (reset) begin
         reset_decoder();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               report("result beat with nothing expected");
            end else begin
               want = expected_pixels.pop_front();
               compare_field("red", rsp_tdata[7:0], want.red);
               compare_field("green", rsp_tdata[15:8], want.green);
               compare_field("blue", rsp_tdata[23:16], want.blue);
               compare_field("alpha", rsp_tdata[31:24], want.alpha);
               compare_field("repeat_count", rsp_tdata[39:32], want.repeat_count);
               compare_field("final_pixel", rsp_tlast, want.final_pixel);
               compare_field("has_alpha", rsp_tuser[0], want.has_alpha);
               compare_field("top_origin", rsp_tuser[1], want.top_origin);
               compare_field("status", rsp_tuser[3:2], want.status);
            end
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            beats_taken++;
         end
      end
   end

   initial begin
      reset_decoder();
      directed_files();
      while (pending_bytes.size() < 800)
         random_file();
      total_beats = pending_bytes.size();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (beats_taken != total_beats || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d of %0d bytes taken, %0d results outstanding",
               beats_taken, total_beats, expected_pixels.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/tga_rle_pkg.sv
rtl/core/tga_rle_pixel_decoder.sv
tb/tb_tga_rle_pixel_decoder.sv
